>>> rtl/bdq_pkg.sv
`default_nettype none
package bdq_pkg;

  // Storage shape.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the item ports.
  localparam int ACT_W     = 4;
  localparam int VALUE_W   = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_PEEK_FRONT = 4'd4,
    ACT_PEEK_BACK  = 4'd5,
    ACT_ROT_NEXT   = 4'd6,
    ACT_ROT_PREV   = 4'd7,
    ACT_CONTAINS   = 4'd8,
    ACT_FIND       = 4'd9
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_ROT
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value_out;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count_out;
  } out_item_t;

  // Write request from the sequencer to the entry store.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    data_t data;
  } wr_req_t;

  // Ring position that lies off entries past base, wrapped at DEPTH.
  // base is below DEPTH and off is at most DEPTH, so one subtract suffices.
  function automatic idx_t slot_add(idx_t base, cnt_t off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return idx_t'(s);
  endfunction

endpackage
`default_nettype wire

>>> rtl/bdq_store.sv
`default_nettype none
module bdq_store (
  input  wire logic            clk,
  input  bdq_pkg::wr_req_t     wr,
  input  bdq_pkg::idx_t        rd_addr,
  output bdq_pkg::data_t       rd_data
);
  import bdq_pkg::*;

  // Ring storage; one write and one registered read per cycle.
  data_t mem_r [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> rtl/bounded_deque_with_rotate_find_top.sv
`default_nettype none
// Channel   Ports                      Handshake
// input     start, busy, in_item       taken at a clock edge with start high and busy low
// result    out_valid, out_item        one-cycle strobe, always taken, no back pressure
//
// Every item gives exactly one result. A push finishes in the execute state, a pop, peek
// or rotate previous first reads one entry, a rotate next makes one rotation step, and a
// search walks the stored entries front to back; a find hit at offset k then rotates k steps.
// Their pace is set by the single registered read port of the entry store, which the
// search walks one entry per cycle and the find rotation reuses one step per cycle.
// Reset (rst_n low, synchronous) empties the queue at once; the store itself is not cleared.
// busy stays high from acceptance until the cycle of the result strobe.
module bounded_deque_with_rotate_find_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  bdq_pkg::in_item_t   in_item,
  output logic                out_valid,
  output bdq_pkg::out_item_t  out_item
);
  import bdq_pkg::*;

  state_t    state_r, state_nxt;
  idx_t      front_r, front_nxt;
  cnt_t      count_r, count_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  data_t     key_r, key_nxt;
  // Scan offset while searching; rotations still to do while rotating.
  cnt_t      off_r, off_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  wr_req_t   wr;
  idx_t      rd_addr;
  data_t     rd_data;
  logic      fin;
  logic      hit;
  data_t     vout;
  status_t   stat;

  bdq_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  // The sequencer. The store's read data always belongs to the address
  // issued in the previous cycle, so each state that consumes read data
  // also issues the read the following state needs.
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    off_nxt   = off_r;
    wr        = '0;
    rd_addr   = front_r;
    fin       = 1'b0;
    vout      = '0;
    stat      = STAT_OK;
    hit       = (rd_data == key_r);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = in_item.action;
          key_nxt   = data_t'(in_item.value);
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (act_r)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            fin = 1'b1;
            if (count_r == cnt_t'(DEPTH)) begin
              stat = STAT_FULL;
            end else begin
              wr.en   = 1'b1;
              wr.data = key_r;
              if (act_r == ACT_PUSH_FRONT) begin
                wr.addr   = slot_add(front_r, cnt_t'(DEPTH - 1));
                front_nxt = wr.addr;
              end else begin
                wr.addr = slot_add(front_r, count_r);
              end
              count_nxt = count_r + cnt_t'(1);
            end
          end
          ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
            if (count_r == '0) begin
              fin  = 1'b1;
              stat = STAT_EMPTY;
            end else begin
              if (act_r == ACT_POP_BACK || act_r == ACT_PEEK_BACK) begin
                rd_addr = slot_add(front_r, count_r - cnt_t'(1));
              end
              state_nxt = ST_READ;
            end
          end
          ACT_ROT_NEXT: begin
            if (count_r < cnt_t'(2)) begin
              fin = 1'b1;
            end else begin
              off_nxt   = cnt_t'(1);
              state_nxt = ST_ROT;
            end
          end
          ACT_ROT_PREV: begin
            if (count_r < cnt_t'(2)) begin
              fin = 1'b1;
            end else begin
              rd_addr   = slot_add(front_r, count_r - cnt_t'(1));
              state_nxt = ST_READ;
            end
          end
          ACT_CONTAINS, ACT_FIND: begin
            if (count_r == '0) begin
              fin  = 1'b1;
              stat = STAT_NOT_FOUND;
            end else begin
              off_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      // Single-entry read has arrived: pop, peek or rotate previous.
      ST_READ: begin
        fin = 1'b1;
        case (act_r)
          ACT_POP_FRONT: begin
            vout      = rd_data;
            front_nxt = slot_add(front_r, cnt_t'(1));
            count_nxt = count_r - cnt_t'(1);
          end
          ACT_POP_BACK: begin
            vout      = rd_data;
            count_nxt = count_r - cnt_t'(1);
          end
          ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
            vout = rd_data;
          end
          ACT_ROT_PREV: begin
            wr.en     = 1'b1;
            wr.addr   = slot_add(front_r, cnt_t'(DEPTH - 1));
            wr.data   = rd_data;
            front_nxt = wr.addr;
          end
          default: begin
            vout = '0;
          end
        endcase
      end

      // One stored entry compared per cycle, front to back.
      ST_SCAN: begin
        if (hit) begin
          if (act_r == ACT_FIND && off_r != '0) begin
            // Rotate off_r steps; the front entry is read now.
            state_nxt = ST_ROT;
          end else begin
            fin = 1'b1;
          end
        end else if (off_r == count_r - cnt_t'(1)) begin
          fin  = 1'b1;
          stat = STAT_NOT_FOUND;
        end else begin
          rd_addr = slot_add(front_r, off_r + cnt_t'(1));
          off_nxt = off_r + cnt_t'(1);
        end
      end

      // One rotate-next step per cycle: the front entry, read in the
      // previous cycle, is copied behind the back and the front advances.
      ST_ROT: begin
        wr.en     = 1'b1;
        wr.addr   = slot_add(front_r, count_r);
        wr.data   = rd_data;
        front_nxt = slot_add(front_r, cnt_t'(1));
        rd_addr   = front_nxt;
        off_nxt   = off_r - cnt_t'(1);
        if (off_r == cnt_t'(1)) begin
          fin = 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
    end

    out_valid_nxt = fin;
    out_item_nxt  = out_item_r;
    if (fin) begin
      out_item_nxt.value_out = VALUE_W'(vout);
      out_item_nxt.status    = stat;
      out_item_nxt.count_out = CNT_OUT_W'(count_nxt);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result is always followed by a return to idle, so strobes never touch.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(DEPTH))
    else $error("entry count exceeds depth");

  a_rot_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT |-> count_r >= cnt_t'(2))
    else $error("rotation step with fewer than two entries");

  a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.count_out == CNT_OUT_W'(count_r))
    else $error("reported count differs from stored count");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

endmodule
`default_nettype wire
